[hw/rtl/median_filter_3x3_top_assert.svh]
// assertion macros for the 3x3 median filter
// used by median_filter_3x3_top; expects clk and rst_n in scope
`ifndef MEDIAN_FILTER_3X3_TOP_ASSERT_SVH
`define MEDIAN_FILTER_3X3_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define MF3_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mf3 assertion failed");

`define MF3_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mf3 assertion failed");

`else

`define MF3_ASSERT_SAME(lbl, ante, cons)

`define MF3_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[hw/rtl/mf3_pkg.sv]
// shared types, constants and compare functions of the 3x3 median filter
// no dependencies
package mf3_pkg;

  localparam int PIX_W    = 8;
  localparam int MAX_COLS = 1024;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int NCOLS_W  = 11;
  localparam int NROWS_W  = 12;
  localparam int LB_W     = 2 * PIX_W;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic REG_NUM_COLS = 1'b0;
  localparam logic REG_NUM_ROWS = 1'b1;

  localparam logic [NCOLS_W-1:0] NUM_COLS_RST = NCOLS_W'(640);
  localparam logic [NROWS_W-1:0] NUM_ROWS_RST = NROWS_W'(480);
  localparam logic [NCOLS_W-1:0] MIN_COLS     = NCOLS_W'(3);
  localparam logic [NCOLS_W-1:0] MAX_COLS_V   = NCOLS_W'(MAX_COLS);
  localparam logic [NROWS_W-1:0] MIN_ROWS     = NROWS_W'(3);
  localparam logic [NROWS_W-1:0] FIRST_ROW    = NROWS_W'(2);
  localparam logic [COL_W-1:0]   FIRST_COL    = COL_W'(2);

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    pix_t hi;
    pix_t md;
    pix_t lo;
  } col_t;

  typedef struct packed {
    logic [NCOLS_W-1:0] cols;
    logic [NROWS_W-1:0] rows;
  } geom_t;

  function automatic pix_t min2(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(input pix_t a, input pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
    return min2(min2(a, b), c);
  endfunction

  function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
    return max2(max2(a, b), c);
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  function automatic col_t sort3(input pix_t a, input pix_t b, input pix_t c);
    col_t s;
    s.lo = min3(a, b, c);
    s.md = med3(a, b, c);
    s.hi = max3(a, b, c);
    return s;
  endfunction

endpackage

[hw/rtl/mf3_ram.sv]
// generic single-clock ram, one write port, one read port, registered read
// no dependencies
module mf3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/mf3_cfg.sv]
// apb configuration registers: frame width and height, clamped geometry out
// depends on mf3_pkg
module mf3_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mf3_pkg::APB_AW-1:0] paddr,
  input  logic [mf3_pkg::APB_DW-1:0] pwdata,
  output logic [mf3_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output mf3_pkg::geom_t              geom
);
  import mf3_pkg::*;

  logic [NCOLS_W-1:0] num_cols_r;
  logic [NROWS_W-1:0] num_rows_r;
  logic               wr_en;
  logic               reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_cols_r <= NUM_COLS_RST;
      num_rows_r <= NUM_ROWS_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_NUM_COLS: num_cols_r <= pwdata[NCOLS_W-1:0];
        REG_NUM_ROWS: num_rows_r <= pwdata[NROWS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_NUM_COLS: prdata = APB_DW'(num_cols_r);
      REG_NUM_ROWS: prdata = APB_DW'(num_rows_r);
      default:      prdata = '0;
    endcase
  end

  always_comb begin
    if (num_cols_r < MIN_COLS) begin
      geom.cols = MIN_COLS;
    end else if (num_cols_r > MAX_COLS_V) begin
      geom.cols = MAX_COLS_V;
    end else begin
      geom.cols = num_cols_r;
    end
    geom.rows = (num_rows_r < MIN_ROWS) ? MIN_ROWS : num_rows_r;
  end

endmodule

[hw/rtl/mf3_median.sv]
// pipelined median of nine from three sorted columns, with output register
// depends on mf3_pkg
module mf3_median (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  output logic                load_rdy,
  input  mf3_pkg::col_t       col0,
  input  mf3_pkg::col_t       col1,
  input  mf3_pkg::col_t       col2,
  input  logic                last_in,
  output logic                out_valid,
  input  logic                out_stall,
  output mf3_pkg::pix_t       median,
  output logic                last_out
);
  import mf3_pkg::*;

  logic s2_v_r, s3_v_r, out_v_r;
  logic rdy_out, rdy3, rdy2;
  col_t s2_c0_r, s2_c1_r, s2_c2_r;
  logic s2_last_r, s3_last_r, out_last_r;
  pix_t s3_lo_r, s3_md_r, s3_hi_r;
  pix_t out_med_r;

  assign rdy_out  = !out_v_r || !out_stall;
  assign rdy3     = !s3_v_r || rdy_out;
  assign rdy2     = !s2_v_r || rdy3;
  assign load_rdy = rdy2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (rdy2) begin
        s2_v_r <= load;
      end
      if (rdy3) begin
        s3_v_r <= s2_v_r;
      end
      if (rdy_out) begin
        out_v_r <= s3_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && load) begin
      s2_c0_r   <= col0;
      s2_c1_r   <= col1;
      s2_c2_r   <= col2;
      s2_last_r <= last_in;
    end
    if (rdy3 && s2_v_r) begin
      s3_lo_r   <= max3(s2_c0_r.lo, s2_c1_r.lo, s2_c2_r.lo);
      s3_md_r   <= med3(s2_c0_r.md, s2_c1_r.md, s2_c2_r.md);
      s3_hi_r   <= min3(s2_c0_r.hi, s2_c1_r.hi, s2_c2_r.hi);
      s3_last_r <= s2_last_r;
    end
    if (rdy_out && s3_v_r) begin
      out_med_r  <= med3(s3_lo_r, s3_md_r, s3_hi_r);
      out_last_r <= s3_last_r;
    end
  end

  assign out_valid = out_v_r;
  assign median    = out_med_r;
  assign last_out  = out_last_r;

endmodule

[hw/rtl/median_filter_3x3_top.sv]
// 3x3 median filter top: raster counters, line buffer ram, column window
// depends on mf3_pkg, mf3_ram, mf3_cfg, mf3_median
// path: stage 1, median s2, s3, output register; throughput: one item per
// cycle unless stalled; the line buffer ram is read at acceptance and
// written back one stage later, one access of each kind per cycle
// reset: counters, window and valid bits cleared, num_cols 640, num_rows 480;
// line buffer contents are not cleared and no clearing pass runs
`include "median_filter_3x3_top_assert.svh"

module median_filter_3x3_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [mf3_pkg::PIX_W-1:0]  in_pixel_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mf3_pkg::PIX_W-1:0]  out_median_out,
  output logic                        out_frame_last,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mf3_pkg::APB_AW-1:0] paddr,
  input  logic [mf3_pkg::APB_DW-1:0] pwdata,
  output logic [mf3_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import mf3_pkg::*;

  geom_t geom;

  logic               acc;
  logic [COL_W-1:0]   col_cnt_r, col_cnt_nxt;
  logic [NROWS_W-1:0] row_cnt_r, row_cnt_nxt;
  logic               row_end, frame_end, emit;

  logic               s1_v_r, s1_emit_r, s1_last_r;
  logic [COL_W-1:0]   s1_addr_r;
  pix_t               s1_pix_r;
  logic               s1_adv;

  logic [LB_W-1:0]    lb_rdata;
  logic [LB_W-1:0]    lb_wdata;
  col_t               new_col;
  col_t               win_r [2];
  logic               med_rdy;

  mf3_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .geom    (geom)
  );

  assign acc = in_valid && !in_stall;

  assign row_end   = (NCOLS_W'(col_cnt_r) + NCOLS_W'(1)) >= geom.cols;
  assign frame_end = row_end &&
                     ((NROWS_W+1)'(row_cnt_r) + (NROWS_W+1)'(1)) >= (NROWS_W+1)'(geom.rows);
  assign emit      = (row_cnt_r >= FIRST_ROW) && (col_cnt_r >= FIRST_COL);

  always_comb begin
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (acc) begin
      if (row_end) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = frame_end ? '0 : row_cnt_r + NROWS_W'(1);
      end else begin
        col_cnt_nxt = col_cnt_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

  // stage 1: line buffer data arrives, column is sorted and shifted in
  assign s1_adv   = s1_v_r && (!s1_emit_r || med_rdy);
  assign in_stall = s1_v_r && !s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (!in_stall) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_emit_r <= emit;
      s1_last_r <= frame_end;
      s1_addr_r <= col_cnt_r;
      s1_pix_r  <= in_pixel_in;
    end
  end

  // ram word: upper row pixel high, middle row pixel low
  mf3_ram #(
    .WIDTH (LB_W),
    .DEPTH (MAX_COLS)
  ) u_lb_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_addr_r),
    .wdata (lb_wdata),
    .re    (acc),
    .raddr (col_cnt_r),
    .rdata (lb_rdata)
  );

  assign lb_wdata = {lb_rdata[PIX_W-1:0], s1_pix_r};
  assign new_col  = sort3(lb_rdata[LB_W-1:PIX_W], lb_rdata[PIX_W-1:0], s1_pix_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r[0] <= '0;
      win_r[1] <= '0;
    end else if (s1_adv) begin
      win_r[0] <= win_r[1];
      win_r[1] <= new_col;
    end
  end

  mf3_median u_median (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (s1_adv && s1_emit_r),
    .load_rdy  (med_rdy),
    .col0      (win_r[0]),
    .col1      (win_r[1]),
    .col2      (new_col),
    .last_in   (s1_last_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .median    (out_median_out),
    .last_out  (out_frame_last)
  );

  `MF3_ASSERT_SAME(a_lb_no_same_addr, acc && s1_adv, col_cnt_r != s1_addr_r)
  `MF3_ASSERT_SAME(a_stall_only_when_busy, in_stall, s1_v_r && s1_emit_r)
  `MF3_ASSERT_NEXT(a_frame_wrap, acc && frame_end, (col_cnt_r == '0) && (row_cnt_r == '0))

endmodule

[sim/tb_top.sv]
// self-checking testbench for median_filter_3x3_top: frames of grey pixels in, medians out
// expected medians come from a raster-order predictor inside a small scoreboard class
// depends on mf3_pkg and median_filter_3x3_top
module tb_top;
  import mf3_pkg::*;

  localparam int WIN_TAPS    = 9;
  localparam int MID_RANK    = 4;
  localparam int PIPE_CYCLES = 4;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int LOOP_ITEMS  = 450;

  typedef struct {
    pix_t median;
    logic last;
  } median_item_t;

  class median_board;
    pix_t               upper_line[MAX_COLS];
    pix_t               middle_line[MAX_COLS];
    pix_t               win[WIN_TAPS];
    logic [NROWS_W-1:0] row_idx;
    int unsigned        col_idx;
    logic [NCOLS_W-1:0] cols_reg;
    logic [NROWS_W-1:0] rows_reg;
    median_item_t       pending_medians[$];
    int unsigned        mismatches;

    function new();
      foreach (upper_line[i]) begin
        upper_line[i] = '0;
        middle_line[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      row_idx = '0;
      col_idx = 0;
      cols_reg = NUM_COLS_RST;
      rows_reg = NUM_ROWS_RST;
      mismatches = 0;
    endfunction

    function int unsigned active_cols();
      if (cols_reg < MIN_COLS) return MIN_COLS;
      if (cols_reg > MAX_COLS_V) return MAX_COLS_V;
      return cols_reg;
    endfunction

    function int unsigned active_rows();
      return (rows_reg < MIN_ROWS) ? MIN_ROWS : rows_reg;
    endfunction

    function int unsigned pending_count();
      return pending_medians.size();
    endfunction

    function void write_reg(logic idx, logic [APB_DW-1:0] data);
      if (idx == REG_NUM_COLS) cols_reg = data[NCOLS_W-1:0];
      else rows_reg = data[NROWS_W-1:0];
    endfunction

    function pix_t median_of_window();
      pix_t s[WIN_TAPS];
      pix_t v;
      int   j;
      s = win;
      for (int i = 1; i < WIN_TAPS; i++) begin
        v = s[i];
        j = i - 1;
        while (j >= 0 && s[j] > v) begin
          s[j+1] = s[j];
          j--;
        end
        s[j+1] = v;
      end
      return s[MID_RANK];
    endfunction

    function void note_pixel(pix_t p);
      int unsigned  slot;
      pix_t         up;
      pix_t         mid;
      bit           row_end;
      bit           frame_end;
      median_item_t item;
      slot = (col_idx < MAX_COLS) ? col_idx : MAX_COLS - 1;
      up = upper_line[slot];
      mid = middle_line[slot];
      row_end = (col_idx + 1 >= active_cols());
      frame_end = row_end && (row_idx + 1 >= active_rows());
      upper_line[slot] = mid;
      middle_line[slot] = p;
      win[0] = win[1]; win[1] = win[2]; win[2] = up;
      win[3] = win[4]; win[4] = win[5]; win[5] = mid;
      win[6] = win[7]; win[7] = win[8]; win[8] = p;
      if (row_idx >= FIRST_ROW && col_idx >= FIRST_COL) begin
        item.median = median_of_window();
        item.last = frame_end;
        pending_medians.push_back(item);
      end
      if (row_end) begin
        col_idx = 0;
        row_idx = frame_end ? '0 : row_idx + 1'b1;
      end else begin
        col_idx++;
      end
    endfunction

    function void check_median(pix_t m, logic last);
      median_item_t want;
      if (pending_medians.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected median %0d last %0b", m, last);
      end else begin
        want = pending_medians.pop_front();
        if (m !== want.median || last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("median mismatch: expected %0d last %0b, got %0d last %0b",
                     want.median, want.last, m, last);
        end
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [PIX_W-1:0]    in_pixel_in;
  logic                out_valid;
  logic                out_stall;
  logic [PIX_W-1:0]    out_median_out;
  logic                out_frame_last;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  median_board board;
  int unsigned cycles = 0;
  int unsigned stall_left = 0;
  bit          quiet_in;
  bit          quiet_out;

  median_filter_3x3_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel_in    (in_pixel_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_median_out (out_median_out),
    .out_frame_last (out_frame_last),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(3, 1);
    return $urandom_range(30, 4);
  endfunction

  function automatic pix_t next_pixel(int style);
    int unsigned r;
    case (style)
      1: begin
        r = $urandom_range(3);
        return (r < 2) ? pix_t'(r) : pix_t'(252 + r);
      end
      2: return pix_t'($urandom_range(103, 100));
      default: return pix_t'($urandom_range(255));
    endcase
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
    if (rst_n) begin
      if (in_valid && !in_stall) board.note_pixel(in_pixel_in);
      if (out_valid && !out_stall) board.check_median(out_median_out, out_frame_last);
    end
  end

  always @(negedge clk) begin
    if (quiet_out) stall_left = 0;
    else if (stall_left == 0 && $urandom_range(99) < 30) stall_left = pick_gap() + 1;
    out_stall <= (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  task automatic feed(input pix_t p);
    int unsigned gap;
    gap = quiet_in ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_pixel_in <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // hold input until every expected median is out and the pipe is empty
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending_count() != 0) @(posedge clk);
    repeat (PIPE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input int unsigned value);
    int unsigned width;
    width = (idx == REG_NUM_COLS) ? NCOLS_W : NROWS_W;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= ($urandom() << width) | value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    board.write_reg(idx, pwdata);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // widening only in row 0, so rows below always find written line buffer entries
  task automatic retune();
    int unsigned widest;
    int unsigned pick;
    int unsigned r;
    int unsigned which;
    widest = (board.row_idx == 0) ? 48 : board.active_cols();
    r = $urandom_range(99);
    if (r < 10) pick = $urandom_range(2, 0);
    else if (r < 80 && widest > 10) pick = $urandom_range(10, 3);
    else pick = $urandom_range(widest, 3);
    which = $urandom_range(2);
    if (which != 1) cfg_write(REG_NUM_COLS, pick);
    r = $urandom_range(99);
    if (r < 10) pick = $urandom_range(2, 0);
    else if (r < 85) pick = $urandom_range(6, 3);
    else pick = $urandom_range(12, 7);
    if (which != 0) cfg_write(REG_NUM_ROWS, pick);
  endtask

  initial begin
    pix_t        spot_frames[18];
    int unsigned loop_items;
    int unsigned burst;
    int          style;
    spot_frames = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd128, 8'd255, 8'd0, 8'd255,
                    8'd0, 8'd9, 8'd8, 8'd7, 8'd6, 8'd5, 8'd4, 8'd3, 8'd2,
                    8'd1};
    board = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_pixel_in = '0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    quiet_in = 1'b0;
    quiet_out = 1'b0;
    loop_items = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // smallest frame with mixed extremes, then out-of-range geometry acting as 3x3
    cfg_write(REG_NUM_COLS, 3);
    cfg_write(REG_NUM_ROWS, 3);
    for (int i = 0; i < 9; i++) feed(spot_frames[i]);
    settle();
    cfg_write(REG_NUM_COLS, 0);
    cfg_write(REG_NUM_ROWS, 0);
    for (int i = 9; i < 18; i++) feed(spot_frames[i]);
    settle();

    // widest rows and tallest frame, cut short by shrinking geometry mid-frame
    cfg_write(REG_NUM_COLS, 2047);
    cfg_write(REG_NUM_ROWS, 4095);
    repeat (MAX_COLS + 30) feed(next_pixel(0));
    settle();
    cfg_write(REG_NUM_ROWS, 0);
    cfg_write(REG_NUM_COLS, 40);
    repeat (10) feed(next_pixel(0));
    settle();
    cfg_write(REG_NUM_COLS, MAX_COLS);
    repeat (10) feed(next_pixel(1));
    settle();
    cfg_write(REG_NUM_COLS, 6);

    while (loop_items < LOOP_ITEMS) begin
      settle();
      if ($urandom_range(99) < 70) retune();
      quiet_in = ($urandom_range(99) < 20);
      quiet_out = ($urandom_range(99) < 20);
      style = ($urandom_range(99) < 70) ? 0 : $urandom_range(2, 1);
      burst = $urandom_range(90, 10);
      repeat (burst) feed(next_pixel(style));
      loop_items += burst;
    end

    settle();
    repeat (10) @(posedge clk);
    if (board.mismatches == 0 && board.pending_count() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule
